>>> rtl/core/camera_vertex_transform_project_top_defines.svh
// assertion macros used by the rtl
`ifndef CAMERA_VERTEX_TRANSFORM_PROJECT_TOP_DEFINES_SVH
`define CAMERA_VERTEX_TRANSFORM_PROJECT_TOP_DEFINES_SVH

// cond must hold whenever trig is seen
`define CVT_ASSERT_IMPLIES(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// cond must hold in the cycle after trig
`define CVT_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

>>> rtl/core/cvt_pkg.sv
package cvt_pkg;

   localparam int SCREEN_W_DEF = 1920;
   localparam int SCREEN_H_DEF = 1080;

   localparam int NUM_W      = 64;
   localparam int QUO_W      = 34;
   localparam int DEN_W      = 31;
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = QUO_W / DIV_BITS;
   localparam int X1_W       = 36;
   localparam int Z2_W       = 38;

   typedef enum logic [2:0] {
      REG_CAM_X       = 3'd0,
      REG_CAM_Y       = 3'd1,
      REG_CAM_Z       = 3'd2,
      REG_YAW_TRIG    = 3'd3,
      REG_PITCH_TRIG  = 3'd4,
      REG_CLIP_NEAR   = 3'd5,
      REG_CLIP_FAR    = 3'd6,
      REG_PROJ_SCALES = 3'd7
   } cvt_reg_type;

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
   } cvt_req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic [30:0]        view_depth;
   } cvt_rsp_type;

   typedef struct packed {
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic [31:0]        yaw_trig;
      logic [31:0]        pitch_trig;
      logic [30:0]        clip_near;
      logic [30:0]        clip_far;
      logic [31:0]        proj_scales;
   } cvt_cfg_type;

   typedef struct packed {
      logic signed [X1_W-1:0] x1;
      logic signed [Z2_W-1:0] y2;
      logic signed [Z2_W-1:0] z2;
   } cvt_view_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] num;
      logic [QUO_W-1:0] quo;
      logic             ovf;
      logic             neg;
   } cvt_lane_type;

   // quotient needs more than QUO_W bits when the top part already reaches the divisor
   function automatic cvt_lane_type cvt_div_load(logic [NUM_W-1:0] num, logic neg,
                                                 logic [DEN_W-1:0] den);
      cvt_lane_type ln;
      ln.rem = DEN_W'(num[NUM_W-1:QUO_W]);
      ln.num = num[QUO_W-1:0];
      ln.quo = '0;
      ln.ovf = (DEN_W'(num[NUM_W-1:QUO_W]) >= den);
      ln.neg = neg;
      return ln;
   endfunction

   // restoring division, DIV_BITS quotient bits
   function automatic cvt_lane_type cvt_div_step(cvt_lane_type ln, logic [DEN_W-1:0] den);
      cvt_lane_type nx;
      logic [DEN_W:0] trial;
      nx = ln;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial  = {nx.rem, nx.num[QUO_W-1]};
         nx.num = {nx.num[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            nx.rem = DEN_W'(trial - {1'b0, den});
            nx.quo = {nx.quo[QUO_W-2:0], 1'b1};
         end else begin
            nx.rem = trial[DEN_W-1:0];
            nx.quo = {nx.quo[QUO_W-2:0], 1'b0};
         end
      end
      return nx;
   endfunction

   // centre plus or minus quotient, saturated to 32 bits
   function automatic logic [31:0] cvt_place(cvt_lane_type ln, logic signed [35:0] centre);
      logic signed [36:0] sum;
      logic               big;
      big = ln.ovf || (ln.quo > (QUO_W'(1) << (QUO_W - 1)));
      if (ln.neg) begin
         sum = 37'(centre) - signed'({3'b000, ln.quo});
      end else begin
         sum = 37'(centre) + signed'({3'b000, ln.quo});
      end
      if (big) begin
         return ln.neg ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if (sum > 37'sd2147483647) begin
         return 32'h7fff_ffff;
      end else if (sum < -37'sd2147483648) begin
         return 32'h8000_0000;
      end else begin
         return sum[31:0];
      end
   endfunction

endpackage

>>> rtl/core/cvt_view.sv
module cvt_view (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  cvt_pkg::cvt_req_type in_data,
   input  cvt_pkg::cvt_cfg_type cfg,
   output logic                 out_valid,
   output cvt_pkg::cvt_view_type out_data
);

   logic signed [15:0] cy, sy, cp, sp;
   logic [4:0]         vld_ff;

   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic signed [48:0] p_xc_ff, p_zs_ff, p_xs_ff, p_zc_ff;
   logic signed [32:0] dy2_ff, dy3_ff;
   logic signed [50:0] sum_x_in, sum_z_in;
   logic signed [cvt_pkg::X1_W-1:0] x1_ff, z1_ff, x1_4_ff;
   logic signed [48:0] q_dc_ff, q_ds_ff;
   logic signed [51:0] q_zs_ff, q_zc_ff;
   logic signed [52:0] sum_y_in, sum_w_in;
   cvt_pkg::cvt_view_type res_ff;

   assign cy = signed'(cfg.yaw_trig[31:16]);
   assign sy = signed'(cfg.yaw_trig[15:0]);
   assign cp = signed'(cfg.pitch_trig[31:16]);
   assign sp = signed'(cfg.pitch_trig[15:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   // offset from camera
   always_ff @(posedge clock) begin
      dx_ff <= 33'(in_data.vertex_x) - 33'(cfg.cam_x);
      dy_ff <= 33'(in_data.vertex_y) - 33'(cfg.cam_y);
      dz_ff <= 33'(in_data.vertex_z) - 33'(cfg.cam_z);
   end

   // yaw products
   always_ff @(posedge clock) begin
      p_xc_ff <= dx_ff * cy;
      p_zs_ff <= dz_ff * sy;
      p_xs_ff <= dx_ff * sy;
      p_zc_ff <= dz_ff * cy;
      dy2_ff  <= dy_ff;
   end

   // round half up, then drop 14 fraction bits
   assign sum_x_in = 51'(p_xc_ff) - 51'(p_zs_ff) + 51'sd8192;
   assign sum_z_in = 51'(p_xs_ff) + 51'(p_zc_ff) + 51'sd8192;

   always_ff @(posedge clock) begin
      x1_ff  <= sum_x_in[49:14];
      z1_ff  <= sum_z_in[49:14];
      dy3_ff <= dy2_ff;
   end

   // pitch products
   always_ff @(posedge clock) begin
      q_dc_ff <= dy3_ff * cp;
      q_zs_ff <= z1_ff * sp;
      q_ds_ff <= dy3_ff * sp;
      q_zc_ff <= z1_ff * cp;
      x1_4_ff <= x1_ff;
   end

   assign sum_y_in = 53'(q_dc_ff) - 53'(q_zs_ff) + 53'sd8192;
   assign sum_w_in = 53'(q_ds_ff) + 53'(q_zc_ff) + 53'sd8192;

   always_ff @(posedge clock) begin
      res_ff.x1 <= x1_4_ff;
      res_ff.y2 <= sum_y_in[51:14];
      res_ff.z2 <= sum_w_in[51:14];
   end

   assign out_valid = vld_ff[4];
   assign out_data  = res_ff;

endmodule

>>> rtl/core/cvt_divider.sv
module cvt_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [cvt_pkg::NUM_W-1:0]          num_x,
   input  logic [cvt_pkg::NUM_W-1:0]          num_y,
   input  logic                               neg_x,
   input  logic                               neg_y,
   input  logic [cvt_pkg::DEN_W-1:0]          depth,
   output logic                               out_valid,
   output cvt_pkg::cvt_lane_type              lane_x,
   output cvt_pkg::cvt_lane_type              lane_y,
   output logic [cvt_pkg::DEN_W-1:0]          out_depth
);

   localparam int N = cvt_pkg::DIV_STAGES;

   logic [N:0]                   vld_ff;
   cvt_pkg::cvt_lane_type        lx_ff    [0:N];
   cvt_pkg::cvt_lane_type        ly_ff    [0:N];
   logic [cvt_pkg::DEN_W-1:0]    depth_ff [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      lx_ff[0]    <= cvt_pkg::cvt_div_load(num_x, neg_x, depth);
      ly_ff[0]    <= cvt_pkg::cvt_div_load(num_y, neg_y, depth);
      depth_ff[0] <= depth;
   end

   for (genvar s = 0; s < N; s++) begin : g_stage
      always_ff @(posedge clock) begin
         lx_ff[s+1]    <= cvt_pkg::cvt_div_step(lx_ff[s], depth_ff[s]);
         ly_ff[s+1]    <= cvt_pkg::cvt_div_step(ly_ff[s], depth_ff[s]);
         depth_ff[s+1] <= depth_ff[s];
      end
   end

   assign out_valid = vld_ff[N];
   assign lane_x    = lx_ff[N];
   assign lane_y    = ly_ff[N];
   assign out_depth = depth_ff[N];

endmodule

>>> rtl/core/camera_vertex_transform_project_top.sv
// a start transfer passes the view pipeline, the clip and multiply registers, the divider and the output register
// throughput: one vertex per cycle, busy stays low; 17 divider stages at 2 bits set the depth
// a clipped vertex gives no strobe
// reset: synchronous, clears valid bits and restores register defaults
// results cannot be held off by the receiver
`include "camera_vertex_transform_project_top_defines.svh"

module camera_vertex_transform_project_top #(
   parameter int SCREEN_W = cvt_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H = cvt_pkg::SCREEN_H_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cvt_pkg::cvt_req_type req_data,
   output logic                 rsp_valid,
   output cvt_pkg::cvt_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam logic signed [35:0] CENTRE_X = 36'(SCREEN_W * 32768);
   localparam logic signed [35:0] CENTRE_Y = 36'(SCREEN_H * 32768);

   cvt_pkg::cvt_cfg_type  cfg_ff;
   logic                  view_vld;
   cvt_pkg::cvt_view_type view;

   logic                  keep_in;
   logic                  clip_vld_ff;
   logic [35:0]           mag_x_ff;
   logic [37:0]           mag_y_ff;
   logic                  neg_x_ff, neg_y_ff;
   logic [30:0]           depth_ff;

   logic                  mul_vld_ff;
   logic [51:0]           prod_x_ff, prod_y_ff;
   logic                  neg_x2_ff, neg_y2_ff;
   logic [30:0]           depth2_ff;

   logic                  div_vld;
   cvt_pkg::cvt_lane_type lane_x, lane_y;
   logic [30:0]           div_depth;

   logic                  rsp_valid_ff;
   cvt_pkg::cvt_rsp_type  rsp_data_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cam_x       <= '0;
         cfg_ff.cam_y       <= '0;
         cfg_ff.cam_z       <= 32'sd327680;
         cfg_ff.yaw_trig    <= 32'h4000_0000;
         cfg_ff.pitch_trig  <= 32'h4000_0000;
         cfg_ff.clip_near   <= 31'd6554;
         cfg_ff.clip_far    <= 31'd6553600;
         cfg_ff.proj_scales <= '0;
      end else if (csr_we) begin
         case (cvt_pkg::cvt_reg_type'(csr_index))
            cvt_pkg::REG_CAM_X:       cfg_ff.cam_x       <= signed'(csr_wdata);
            cvt_pkg::REG_CAM_Y:       cfg_ff.cam_y       <= signed'(csr_wdata);
            cvt_pkg::REG_CAM_Z:       cfg_ff.cam_z       <= signed'(csr_wdata);
            cvt_pkg::REG_YAW_TRIG:    cfg_ff.yaw_trig    <= csr_wdata;
            cvt_pkg::REG_PITCH_TRIG:  cfg_ff.pitch_trig  <= csr_wdata;
            cvt_pkg::REG_CLIP_NEAR:   cfg_ff.clip_near   <= csr_wdata[30:0];
            cvt_pkg::REG_CLIP_FAR:    cfg_ff.clip_far    <= csr_wdata[30:0];
            cvt_pkg::REG_PROJ_SCALES: cfg_ff.proj_scales <= csr_wdata;
            default: ;
         endcase
      end
   end

   cvt_view u_view (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (view_vld),
      .out_data  (view)
   );

   // depth clip against near and far planes
   assign keep_in = view_vld && !view.z2[cvt_pkg::Z2_W-1]
                    && (view.z2[cvt_pkg::Z2_W-2:0] >= 37'(cfg_ff.clip_near))
                    && (view.z2[cvt_pkg::Z2_W-2:0] <= 37'(cfg_ff.clip_far));

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_vld_ff <= 1'b0;
      end else begin
         clip_vld_ff <= keep_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_x_ff <= view.x1[35] ? 36'(-view.x1) : 36'(view.x1);
      mag_y_ff <= view.y2[37] ? 38'(-view.y2) : 38'(view.y2);
      neg_x_ff <= view.x1[35];
      // y points down on screen
      neg_y_ff <= !view.y2[37];
      depth_ff <= (view.z2[30:0] == 31'd0) ? 31'd1 : view.z2[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= clip_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= mag_x_ff * cfg_ff.proj_scales[31:16];
      prod_y_ff <= 52'(mag_y_ff * cfg_ff.proj_scales[15:0]);
      neg_x2_ff <= neg_x_ff;
      neg_y2_ff <= neg_y_ff;
      depth2_ff <= depth_ff;
   end

   cvt_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_vld_ff),
      .num_x     ({prod_x_ff, 12'd0}),
      .num_y     ({prod_y_ff, 12'd0}),
      .neg_x     (neg_x2_ff),
      .neg_y     (neg_y2_ff),
      .depth     (depth2_ff),
      .out_valid (div_vld),
      .lane_x    (lane_x),
      .lane_y    (lane_y),
      .out_depth (div_depth)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff.screen_x   <= signed'(cvt_pkg::cvt_place(lane_x, CENTRE_X));
      rsp_data_ff.screen_y   <= signed'(cvt_pkg::cvt_place(lane_y, CENTRE_Y));
      rsp_data_ff.view_depth <= div_depth;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CVT_ASSERT_IMPLIES(a_depth_nonzero, rsp_valid, rsp_data.view_depth != 31'd0, "zero depth out")
   `CVT_ASSERT_IMPLIES(a_clip_order, clip_vld_ff, cfg_ff.clip_near <= cfg_ff.clip_far, "kept with near above far")
   `CVT_ASSERT_NEXT(a_sat_x, div_vld && lane_x.ovf && !lane_x.neg, rsp_data.screen_x == 32'sh7fff_ffff, "x overflow not saturated")

endmodule

>>> test/camera_vertex_transform_project_checker.sv
module camera_vertex_transform_project_checker
   import cvt_pkg::*;
#(
   parameter int SCREEN_W = SCREEN_W_DEF,
   parameter int SCREEN_H = SCREEN_H_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  cvt_req_type req_data,
   input  logic        rsp_valid,
   input  cvt_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   cvt_cfg_type cfg;
   cvt_rsp_type screen_q[$];

   // floor of (p + half lsb) / 2^14
   function automatic longint rotate_round(longint p);
      return (p + 64'sd8192) >>> 14;
   endfunction

   function automatic logic [31:0] place_on_screen(longint coord, longint unsigned scale,
                                                   longint unsigned depth, longint centre,
                                                   bit flip);
      bit              neg;
      longint unsigned mag;
      longint unsigned q;
      longint          r;
      neg = coord < 0;
      mag = neg ? longint'(-coord) : longint'(coord);
      // wraps at 64 bits like the hardware numerator
      q = ((mag * scale) << 12) / depth;
      if (flip) neg = !neg;
      if (q > (64'd1 << 33)) begin
         r = neg ? -64'sd2147483648 : 64'sd2147483647;
      end else begin
         r = neg ? centre - longint'(q) : centre + longint'(q);
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
      end
      return r[31:0];
   endfunction

   function automatic bit project_vertex(cvt_cfg_type c, cvt_req_type v,
                                         output cvt_rsp_type s);
      longint dx, dy, dz, cy, sy, cp, sp, x1, z1, y2, z2;
      dx = longint'(v.vertex_x) - longint'(c.cam_x);
      dy = longint'(v.vertex_y) - longint'(c.cam_y);
      dz = longint'(v.vertex_z) - longint'(c.cam_z);
      cy = longint'($signed(c.yaw_trig[31:16]));
      sy = longint'($signed(c.yaw_trig[15:0]));
      cp = longint'($signed(c.pitch_trig[31:16]));
      sp = longint'($signed(c.pitch_trig[15:0]));
      x1 = rotate_round(dx * cy - dz * sy);
      z1 = rotate_round(dx * sy + dz * cy);
      y2 = rotate_round(dy * cp - z1 * sp);
      z2 = rotate_round(dy * sp + z1 * cp);
      s = '0;
      if (z2 < longint'(c.clip_near) || z2 > longint'(c.clip_far)) return 0;
      if (z2 == 0) z2 = 1;
      s.screen_x   = place_on_screen(x1, c.proj_scales[31:16], z2,
                                     longint'(SCREEN_W) * 32768, 0);
      s.screen_y   = place_on_screen(y2, c.proj_scales[15:0], z2,
                                     longint'(SCREEN_H) * 32768, 1);
      s.view_depth = z2[30:0];
      return 1;
   endfunction

   assign pending = screen_q.size();

   always @(posedge clock) begin
      cvt_rsp_type want;
      if (reset) begin
         cfg.cam_x       <= '0;
         cfg.cam_y       <= '0;
         cfg.cam_z       <= 32'sd327680;
         cfg.yaw_trig    <= 32'h4000_0000;
         cfg.pitch_trig  <= 32'h4000_0000;
         cfg.clip_near   <= 31'd6554;
         cfg.clip_far    <= 31'd6553600;
         cfg.proj_scales <= '0;
         screen_q.delete();
         fail_count <= 0;
      end else begin
         if (start && !busy && project_vertex(cfg, req_data, want))
            screen_q.push_back(want);
         if (rsp_valid) begin
            if (screen_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = screen_q.pop_front();
               if (rsp_data.screen_x !== want.screen_x ||
                   rsp_data.screen_y !== want.screen_y ||
                   rsp_data.view_depth !== want.view_depth) begin
                  if (rsp_data.screen_x !== want.screen_x)
                     $display("%0t: screen_x expected %h got %h", $time,
                              want.screen_x, rsp_data.screen_x);
                  if (rsp_data.screen_y !== want.screen_y)
                     $display("%0t: screen_y expected %h got %h", $time,
                              want.screen_y, rsp_data.screen_y);
                  if (rsp_data.view_depth !== want.view_depth)
                     $display("%0t: view_depth expected %h got %h", $time,
                              want.view_depth, rsp_data.view_depth);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) begin
            case (cvt_reg_type'(csr_index))
               REG_CAM_X:       cfg.cam_x       <= csr_wdata;
               REG_CAM_Y:       cfg.cam_y       <= csr_wdata;
               REG_CAM_Z:       cfg.cam_z       <= csr_wdata;
               REG_YAW_TRIG:    cfg.yaw_trig    <= csr_wdata;
               REG_PITCH_TRIG:  cfg.pitch_trig  <= csr_wdata;
               REG_CLIP_NEAR:   cfg.clip_near   <= csr_wdata[30:0];
               REG_CLIP_FAR:    cfg.clip_far    <= csr_wdata[30:0];
               REG_PROJ_SCALES: cfg.proj_scales <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

>>> test/camera_vertex_transform_project_top_tb.sv
module camera_vertex_transform_project_top_tb;
   import cvt_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   cvt_req_type req_data = '0;
   logic        rsp_valid;
   cvt_rsp_type rsp_data;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          pending;

   // shadow of the camera so random vertices can be placed in front of it
   logic [31:0] cam_x_sh, cam_y_sh, cam_z_sh;
   int          idle_pct;

   always #5 clock = ~clock;

   camera_vertex_transform_project_top u_top (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_we, .csr_index, .csr_wdata
   );

   camera_vertex_transform_project_checker u_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_we, .csr_index, .csr_wdata, .fail_count, .pending
   );

   task automatic csr_write(cvt_reg_type idx, logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 0;
      case (idx)
         REG_CAM_X: cam_x_sh = data;
         REG_CAM_Y: cam_y_sh = data;
         REG_CAM_Z: cam_z_sh = data;
         default: ;
      endcase
   endtask

   task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start    <= 1;
      req_data <= {vx, vy, vz};
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // clipped vertices give no strobe, so let the pipeline empty fully
   task automatic drain();
      start <= 0;
      @(negedge clock);
      wait (pending == 0);
      repeat (30) @(negedge clock);
   endtask

   task automatic random_vertex();
      logic [31:0] off;
      case ($urandom_range(9))
         0: send_vertex($urandom, $urandom, $urandom);
         1: send_vertex(cam_x_sh, cam_y_sh, cam_z_sh);
         default: begin
            off = $urandom_range(32'h0020_0000);
            send_vertex(cam_x_sh + ($urandom_range(32'h0008_0000) - 32'h0004_0000),
                        cam_y_sh + ($urandom_range(32'h0008_0000) - 32'h0004_0000),
                        cam_z_sh + off);
         end
      endcase
   endtask

   initial begin
      cam_x_sh = 0;
      cam_y_sh = 0;
      cam_z_sh = 32'd327680;
      idle_pct = 0;
      repeat (7) @(negedge clock);
      reset <= 0;

      // defaults: zero scales put every kept vertex on the centre
      send_vertex(0, 0, 32'h0006_0000);
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0006_0000);
      drain();
      csr_write(REG_PROJ_SCALES, 32'h0400_0400);
      drain();
      send_vertex(0, 0, 32'd327680 + 32'd6554);        // exactly on near
      send_vertex(0, 0, 32'd327680 + 32'd6553);        // just in front of near
      send_vertex(0, 0, 32'd327680 + 32'd6553600);     // exactly on far
      send_vertex(0, 0, 32'd327680 + 32'd6553601);     // just past far
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h0006_0000);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h0006_0000);
      send_vertex(32'h0001_0000, 32'hffff_0000, 32'h0007_0000);
      send_vertex(0, 0, 32'h7fff_ffff);
      send_vertex(0, 0, 32'h8000_0000);
      send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_vertex(0, 0, 0);
      drain();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: ;
            1: begin
               // zero near plane lets a vertex sit on the camera
               csr_write(REG_CAM_X, $urandom_range(32'h0010_0000));
               csr_write(REG_CAM_Y, -$urandom_range(32'h0010_0000));
               csr_write(REG_CLIP_NEAR, 0);
               csr_write(REG_CLIP_FAR, 32'h7fff_ffff);
            end
            2: begin
               csr_write(REG_CAM_X, 32'h8000_0000);
               csr_write(REG_CAM_Y, 32'h7fff_ffff);
               csr_write(REG_CAM_Z, 32'h8000_0000);
               csr_write(REG_YAW_TRIG, 32'h8000_8000);
               csr_write(REG_PITCH_TRIG, 32'h7fff_7fff);
               csr_write(REG_PROJ_SCALES, 32'hffff_ffff);
            end
            3: begin
               // near beyond far drops everything
               csr_write(REG_CLIP_NEAR, 32'h0010_0000);
               csr_write(REG_CLIP_FAR, 32'h0000_1000);
            end
            default: begin
               csr_write(REG_CAM_X, $urandom_range(32'h0100_0000) - 32'h0080_0000);
               csr_write(REG_CAM_Y, $urandom_range(32'h0100_0000) - 32'h0080_0000);
               csr_write(REG_CAM_Z, $urandom_range(32'h0100_0000) - 32'h0080_0000);
               csr_write(REG_YAW_TRIG, (p == 4) ? 32'h4000_0000 : $urandom);
               csr_write(REG_PITCH_TRIG, (p < 6) ? 32'h3b21_187e : $urandom);
               csr_write(REG_CLIP_NEAR, $urandom_range(32'h0000_4000));
               csr_write(REG_CLIP_FAR, $urandom_range(32'h7fff_ffff, 32'h0010_0000));
               csr_write(REG_PROJ_SCALES, $urandom);
            end
         endcase
         idle_pct = (p % 4 == 1) ? 79 : (p % 4 == 3) ? 30 : 0;
         for (int i = 0; i < ((p == 3) ? 40 : 150); i++) begin
            if (i % 50 == 49) idle_pct = 0;
            random_vertex();
         end
         drain();
      end

      if (fail_count == 0)
         $display("camera_vertex_transform_project_top_tb passed");
      else
         $display("camera_vertex_transform_project_top_tb failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("camera_vertex_transform_project_top_tb failed");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/cvt_pkg.sv
rtl/core/cvt_view.sv
rtl/core/cvt_divider.sv
rtl/core/camera_vertex_transform_project_top.sv
test/camera_vertex_transform_project_checker.sv
test/camera_vertex_transform_project_top_tb.sv
